@@ design/rgk_pkg.sv @@
// rgk_pkg: shared types and constants for the group-reversing stream block.
// No dependencies.

package rgk_pkg;

    localparam int MAX_GROUP  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = $clog2(MAX_GROUP);
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int ADDR_W     = IDX_W + 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         list_end;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] out_value;
        logic                         run_last;
        logic                         out_list_end;
    } out_item_t;

    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic [DATA_WIDTH-1:0]   data;
    } wr_req_t;

    typedef struct packed {
        logic             start;
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             list_end;
    } drain_req_t;

endpackage

@@ design/rgk_drain.sv @@
// rgk_drain: two-bank group memory with the read sequencer and output register.
// Depends on rgk_pkg.

module rgk_drain
(
    input  logic                clk,
    input  logic                rst_n,
    input  rgk_pkg::wr_req_t    wr,
    input  rgk_pkg::drain_req_t req,
    output logic                busy,
    output logic                dst_valid,
    input  logic                dst_stall,
    output rgk_pkg::out_item_t  dst_data
);

    logic [rgk_pkg::DATA_WIDTH-1:0] mem [1 << rgk_pkg::ADDR_W];

    logic                       act_reg, act_next;
    logic                       bank_reg;
    logic [rgk_pkg::CNT_W-1:0]  n_reg;
    logic                       rev_reg;
    logic                       end_reg;
    logic [rgk_pkg::CNT_W-1:0]  i_reg, i_next;

    logic                           rd_vld_reg, rd_vld_next;
    logic [rgk_pkg::DATA_WIDTH-1:0] rd_data_reg;
    logic                           rd_last_reg;
    logic                           rd_end_reg;

    logic                 out_vld_reg, out_vld_next;
    rgk_pkg::out_item_t   out_reg;

    logic                       mv;
    logic                       rd_en;
    logic                       last;
    logic [rgk_pkg::CNT_W-1:0]  idx;
    logic [rgk_pkg::ADDR_W-1:0] rd_addr;

    assign mv    = rd_vld_reg && (!out_vld_reg || !dst_stall);
    assign rd_en = act_reg && (!rd_vld_reg || mv);
    assign last  = (i_reg + rgk_pkg::CNT_W'(1)) == n_reg;
    assign idx   = rev_reg ? (n_reg - rgk_pkg::CNT_W'(1) - i_reg) : i_reg;
    assign rd_addr = {bank_reg, idx[rgk_pkg::IDX_W-1:0]};

    always_comb
    begin
        act_next = act_reg;
        i_next   = i_reg;
        if (req.start)
        begin
            act_next = 1'b1;
            i_next   = '0;
        end
        else if (rd_en)
        begin
            i_next = i_reg + rgk_pkg::CNT_W'(1);
            if (last)
                act_next = 1'b0;
        end
    end

    always_comb
    begin
        rd_vld_next = rd_vld_reg;
        if (rd_en)
            rd_vld_next = 1'b1;
        else if (mv)
            rd_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (mv)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !dst_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg     <= 1'b0;
            i_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            act_reg     <= act_next;
            i_reg       <= i_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            bank_reg <= req.bank;
            n_reg    <= req.count;
            rev_reg  <= req.rev;
            end_reg  <= req.list_end;
        end
        if (rd_en)
        begin
            rd_last_reg <= last;
            rd_end_reg  <= last && end_reg;
        end
        if (mv)
        begin
            out_reg.out_value    <= rd_data_reg;
            out_reg.run_last     <= rd_last_reg;
            out_reg.out_list_end <= rd_end_reg;
        end
    end

    assign busy      = act_reg;
    assign dst_valid = out_vld_reg;
    assign dst_data  = out_reg;

endmodule

@@ design/stream_reverse_in_groups_of_k_core.sv @@
// stream_reverse_in_groups_of_k_core: top level, fill control and group size register.
// Depends on rgk_pkg and rgk_drain.
//
//  channel  signals                      direction  payload
//  src      src_valid/src_stall/src_data in         value, list_end
//  dst      dst_valid/dst_stall/dst_data out        out_value, run_last, out_list_end
//  cfg      cfg_valid/cfg_ready/cfg_data in         group_size
//
// One item is taken per cycle while it only fills a bank.
// An item that closes a group starts a drain; results leave one per cycle while dst_stall
// is low, through the memory read register and the output register.
// An item that would close a group is stalled while the previous group is still issuing
// reads, so a group of n holds the read port for n reads.
// Reset (rst_n, async) empties the fill count, selects bank 0, sets group size 1.

module stream_reverse_in_groups_of_k_core
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_stall,
    input  rgk_pkg::in_item_t        src_data,
    output logic                     dst_valid,
    input  logic                     dst_stall,
    output rgk_pkg::out_item_t       dst_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rgk_pkg::CFG_W-1:0] cfg_data
);

    logic [rgk_pkg::CFG_W-1:0] gsize_reg;
    logic [rgk_pkg::CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic                      fill_bank_reg, fill_bank_next;

    logic [rgk_pkg::CNT_W-1:0] k;
    logic [rgk_pkg::CNT_W-1:0] n;
    logic                      full;
    logic                      trigger;
    logic                      accept;
    logic                      busy;

    rgk_pkg::wr_req_t    wr;
    rgk_pkg::drain_req_t req;

    always_comb
    begin
        if (gsize_reg == '0)
            k = rgk_pkg::CNT_W'(1);
        else if (32'(gsize_reg) > rgk_pkg::MAX_GROUP)
            k = rgk_pkg::CNT_W'(rgk_pkg::MAX_GROUP);
        else
            k = rgk_pkg::CNT_W'(gsize_reg);
    end

    assign n         = fill_cnt_reg + rgk_pkg::CNT_W'(1);
    assign full      = n >= k;
    assign trigger   = full || src_data.list_end;
    assign src_stall = busy && trigger;
    assign accept    = src_valid && !src_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        fill_cnt_next  = fill_cnt_reg;
        fill_bank_next = fill_bank_reg;
        if (accept)
        begin
            if (trigger)
            begin
                fill_cnt_next  = '0;
                fill_bank_next = !fill_bank_reg;
            end
            else
            begin
                fill_cnt_next = n;
            end
        end
    end

    always_comb
    begin
        wr.en        = accept;
        wr.addr      = {fill_bank_reg, fill_cnt_reg[rgk_pkg::IDX_W-1:0]};
        wr.data      = src_data.value;
        req.start    = accept && trigger;
        req.bank     = fill_bank_reg;
        req.count    = n;
        req.rev      = full;
        req.list_end = src_data.list_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg     <= rgk_pkg::CFG_W'(1);
            fill_cnt_reg  <= '0;
            fill_bank_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gsize_reg <= cfg_data;
            fill_cnt_reg  <= fill_cnt_next;
            fill_bank_reg <= fill_bank_next;
        end
    end

    rgk_drain u_drain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .req       (req),
        .busy      (busy),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_cnt_reg) < rgk_pkg::MAX_GROUP)
        else $error("fill count out of range");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy)
        else $error("drain did not start");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_data.out_list_end) |-> dst_data.run_last)
        else $error("list end on a result that is not the last of its run");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (fill_bank_reg != $past(fill_bank_reg) && fill_cnt_reg == '0))
        else $error("bank not switched after group close");

endmodule
